>>> design/slab_size_class_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Slab size-class allocator assertion macros
// Shared assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef SLAB_SIZE_CLASS_ALLOCATOR_TOP_MACROS_SVH
`define SLAB_SIZE_CLASS_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SSCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slab allocator assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SSCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slab allocator assertion failed");
`else
`define SSCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/ssca_pkg.sv
// ----------------------------------------------------------------------------
// Slab size-class allocator package
// Constants, codes, control types and the size-to-class decoder.
// ----------------------------------------------------------------------------
package ssca_pkg;

    // Field and state widths.
    localparam int SIZE_W       = 21;
    localparam int ADDR_W       = 26;
    localparam int CLASS_W      = 5;
    localparam int REM_W        = 18;
    localparam int PAGE_CNT_W   = 7;
    localparam int FREE_PTR_W   = 8;
    localparam int FREE_CNT_W   = FREE_PTR_W + 1;
    localparam int STACK_AW     = 13;

    // Allocator geometry.
    localparam int NUM_CLASSES  = 18;
    localparam int FREE_DEPTH   = 256;
    localparam int STACK_DEPTH  = NUM_CLASSES * FREE_DEPTH;

    localparam logic [CLASS_W-1:0]    SMALLEST_CLASS = 5'd3;
    localparam logic [CLASS_W-1:0]    LARGEST_CLASS  = 5'd20;
    localparam logic [CLASS_W-1:0]    PAGE_LOG2      = 5'd20;
    localparam logic [SIZE_W-1:0]     PAGE_BYTES     = 21'd1048576;
    localparam logic [PAGE_CNT_W-1:0] POOL_PAGES     = 7'd64;

    // Configuration register index (word address bit).
    localparam logic CFG_IDX_PAGE_LIMIT = 1'b0;

    // Request operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_SIZE = 2'd1,
        STAT_OOM  = 2'd2,
        STAT_FULL = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic pop_finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_pop;
    } dp_stat_t;

    // Decoded size class.
    typedef struct packed {
        logic               valid;
        logic [CLASS_W-1:0] cls;
    } class_info_t;

    // Class is the bit length of size-1 (at least 1), raised to the smallest
    // class; sizes of zero or beyond one page are rejected.
    function automatic class_info_t class_decode(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0]  v;
        logic [CLASS_W-1:0] msb;
        logic [CLASS_W-1:0] c;
        class_info_t        info;
        v   = size - SIZE_W'(1);
        msb = '0;
        for (int i = 1; i < SIZE_W; i++) begin
            if (v[i]) begin
                msb = CLASS_W'(i);
            end
        end
        c = msb + CLASS_W'(1);
        if (c < SMALLEST_CLASS) begin
            c = SMALLEST_CLASS;
        end
        info.valid = (size != '0) && (c <= LARGEST_CLASS) && (c <= PAGE_LOG2);
        info.cls   = info.valid ? c : '0;
        return info;
    endfunction

endpackage

>>> design/ssca_stack_mem.sv
// ----------------------------------------------------------------------------
// Slab allocator free-stack memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssca_stack_mem (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [ssca_pkg::STACK_AW-1:0]  wr_addr,
    input  logic [ssca_pkg::ADDR_W-1:0]    wr_data,
    input  logic                           rd_en,
    input  logic [ssca_pkg::STACK_AW-1:0]  rd_addr,
    output logic [ssca_pkg::ADDR_W-1:0]    rd_data
);
    import ssca_pkg::*;

    logic [ADDR_W-1:0] mem_reg [STACK_DEPTH];
    logic [ADDR_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/ssca_ctrl.sv
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences capture, execute and the optional free-stack pop read.
// ----------------------------------------------------------------------------
`include "slab_size_class_allocator_top_macros.svh"

module ssca_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ssca_pkg::dp_stat_t dp_stat,
    output ssca_pkg::dp_cmd_t  dp_cmd
);
    import ssca_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next         = state_reg;
        dp_cmd.capture     = 1'b0;
        dp_cmd.exec        = 1'b0;
        dp_cmd.pop_finish  = 1'b0;
        busy               = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                dp_cmd.exec = 1'b1;
                state_next  = dp_stat.need_pop ? ST_POP : ST_IDLE;
            end
            ST_POP:
            begin
                dp_cmd.pop_finish = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencing checks.
    `SSCA_ASSERT_NXT(a_start_execs, clk, rst_n, (state_reg == ST_IDLE) && start, state_reg == ST_EXEC)
    `SSCA_ASSERT_NXT(a_exec_one_cycle, clk, rst_n, state_reg == ST_EXEC, state_reg != ST_EXEC)
    `SSCA_ASSERT_IMP(a_pop_after_exec, clk, rst_n, state_reg == ST_POP, $past(state_reg) == ST_EXEC)

endmodule

>>> design/ssca_datapath.sv
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Request capture, class decode, per-class carve state, page pool and results.
// ----------------------------------------------------------------------------
`include "slab_size_class_allocator_top_macros.svh"

module ssca_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ssca_pkg::dp_cmd_t                 dp_cmd,
    output ssca_pkg::dp_stat_t                dp_stat,
    input  logic                              operation,
    input  logic [ssca_pkg::SIZE_W-1:0]       request_size,
    input  logic [ssca_pkg::ADDR_W-1:0]       address,
    input  logic                              cfg_we,
    input  logic [ssca_pkg::PAGE_CNT_W-1:0]   cfg_wdata,
    output logic [ssca_pkg::PAGE_CNT_W-1:0]   page_limit,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [ssca_pkg::ADDR_W-1:0]       chunk_address,
    output logic [ssca_pkg::CLASS_W-1:0]      size_class
);
    import ssca_pkg::*;

    // Captured request.
    logic                  op_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [ADDR_W-1:0]     addr_reg;

    // Configuration and pool state.
    logic [PAGE_CNT_W-1:0] page_limit_reg;
    logic [PAGE_CNT_W-1:0] pages_used_reg;
    logic [PAGE_CNT_W-1:0] pages_used_next;

    // Per-class state.
    logic [ADDR_W-1:0]     carve_addr_reg [NUM_CLASSES];
    logic [REM_W-1:0]      carve_rem_reg  [NUM_CLASSES];
    logic [FREE_CNT_W-1:0] free_cnt_reg   [NUM_CLASSES];
    logic [ADDR_W-1:0]     carve_addr_next;
    logic [REM_W-1:0]      carve_rem_next;
    logic [FREE_CNT_W-1:0] free_cnt_next;

    // Results.
    logic                  done_reg;
    logic                  done_next;
    status_t               status_reg;
    status_t               status_next;
    logic [ADDR_W-1:0]     result_addr_reg;
    logic [ADDR_W-1:0]     result_addr_next;
    logic [CLASS_W-1:0]    result_class_reg;

    // Decode and lookup.
    class_info_t           info;
    logic [CLASS_W-1:0]    k_idx;
    logic [ADDR_W-1:0]     cur_addr;
    logic [REM_W-1:0]      cur_rem;
    logic [FREE_CNT_W-1:0] cur_cnt;
    logic [FREE_CNT_W-1:0] cnt_dec;
    logic [ADDR_W-1:0]     chunk_bytes;
    logic [ADDR_W-1:0]     page_base;
    logic [SIZE_W-1:0]     page_slot_count;
    logic [PAGE_CNT_W-1:0] limit;

    // Free-stack memory ports.
    logic                  mem_we;
    logic                  mem_re;
    logic [STACK_AW-1:0]   mem_waddr;
    logic [STACK_AW-1:0]   mem_raddr;
    logic [ADDR_W-1:0]     mem_rdata;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg   <= operation;
            size_reg <= request_size;
            addr_reg <= address;
        end
    end

    // Class decode and per-class lookup.
    always_comb
    begin
        info            = class_decode(size_reg);
        k_idx           = info.valid ? (info.cls - SMALLEST_CLASS) : '0;
        cur_addr        = carve_addr_reg[k_idx];
        cur_rem         = carve_rem_reg[k_idx];
        cur_cnt         = free_cnt_reg[k_idx];
        cnt_dec         = cur_cnt - FREE_CNT_W'(1);
        chunk_bytes     = ADDR_W'(1) << info.cls;
        page_base       = ADDR_W'(pages_used_reg) << PAGE_LOG2;
        page_slot_count = PAGE_BYTES >> info.cls;
        limit           = ((page_limit_reg != '0) && (page_limit_reg < POOL_PAGES)) ?
                          page_limit_reg : POOL_PAGES;
        dp_stat.need_pop = info.valid && (op_reg == OP_ALLOC) && (cur_cnt != '0);
    end

    // Request execution.
    always_comb
    begin
        carve_addr_next  = cur_addr;
        carve_rem_next   = cur_rem;
        free_cnt_next    = cur_cnt;
        pages_used_next  = pages_used_reg;
        status_next      = STAT_OK;
        result_addr_next = '0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = {k_idx, cur_cnt[FREE_PTR_W-1:0]};
        mem_raddr        = {k_idx, cnt_dec[FREE_PTR_W-1:0]};
        done_next        = dp_cmd.pop_finish || (dp_cmd.exec && !dp_stat.need_pop);
        if (!info.valid)
        begin
            status_next = STAT_SIZE;
        end
        else if (op_reg == OP_FREE)
        begin
            if (cur_cnt[FREE_CNT_W-1])
            begin
                status_next = STAT_FULL;
            end
            else
            begin
                mem_we        = dp_cmd.exec;
                free_cnt_next = cur_cnt + FREE_CNT_W'(1);
            end
        end
        else if (cur_cnt != '0)
        begin
            mem_re        = dp_cmd.exec;
            free_cnt_next = cnt_dec;
        end
        else if (cur_rem != '0)
        begin
            result_addr_next = cur_addr;
            carve_rem_next   = cur_rem - REM_W'(1);
            carve_addr_next  = cur_addr + chunk_bytes;
        end
        else if (pages_used_reg >= limit)
        begin
            status_next = STAT_OOM;
        end
        else
        begin
            result_addr_next = page_base;
            pages_used_next  = pages_used_reg + PAGE_CNT_W'(1);
            carve_addr_next  = page_base + chunk_bytes;
            carve_rem_next   = REM_W'(page_slot_count - SIZE_W'(1));
        end
    end

    // Configuration, pool and per-class state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_limit_reg <= '0;
            pages_used_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                carve_addr_reg[i] <= '0;
                carve_rem_reg[i]  <= '0;
                free_cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                page_limit_reg <= cfg_wdata;
            end
            if (dp_cmd.exec)
            begin
                pages_used_reg        <= pages_used_next;
                carve_addr_reg[k_idx] <= carve_addr_next;
                carve_rem_reg[k_idx]  <= carve_rem_next;
                free_cnt_reg[k_idx]   <= free_cnt_next;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Result payload; a pop takes its address from the stack read.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            status_reg       <= status_next;
            result_addr_reg  <= result_addr_next;
            result_class_reg <= info.cls;
        end
        else if (dp_cmd.pop_finish)
        begin
            status_reg      <= STAT_OK;
            result_addr_reg <= mem_rdata;
        end
    end

    ssca_stack_mem u_stack_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (addr_reg),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign page_limit    = page_limit_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign chunk_address = result_addr_reg;
    assign size_class    = result_class_reg;

    // Result consistency checks.
    `SSCA_ASSERT_IMP(a_fail_zero_addr, clk, rst_n, done_reg && (status_reg != STAT_OK), result_addr_reg == '0)
    `SSCA_ASSERT_IMP(a_reject_class0, clk, rst_n, done_reg && (status_reg == STAT_SIZE), result_class_reg == '0)
    `SSCA_ASSERT_NXT(a_pool_monotonic, clk, rst_n, 1'b1, pages_used_reg >= $past(pages_used_reg))

endmodule

>>> design/slab_size_class_allocator_top.sv
// A request accepted in idle is captured, executed in the EXEC state and its result strobe
// registered; an allocate served from a class free stack adds the POP state (free-stack memory read).
// A new request is taken only in the idle state; busy is high while one is in flight.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (rst_n, asynchronous, active low) clears the page count, page limit and per-class
// state at once; free-stack contents need no clearing, so no idle sweep follows reset.
// ----------------------------------------------------------------------------
// Slab size-class allocator top level
// Power-of-two slab allocator with a command port and an APB register port.
// ----------------------------------------------------------------------------
module slab_size_class_allocator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // Command channel.
    input  logic                             start,
    output logic                             busy,
    input  logic                             operation,
    input  logic [ssca_pkg::SIZE_W-1:0]      request_size,
    input  logic [ssca_pkg::ADDR_W-1:0]      address,
    // Result channel.
    output logic                             done,
    output logic [1:0]                       status,
    output logic [ssca_pkg::ADDR_W-1:0]      chunk_address,
    output logic [ssca_pkg::CLASS_W-1:0]     size_class,
    // Register port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import ssca_pkg::*;

    dp_cmd_t               dp_cmd;
    dp_stat_t              dp_stat;
    logic                  cfg_we;
    logic [PAGE_CNT_W-1:0] page_limit;

    // Register decode; a transfer completes with zero wait states.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == CFG_IDX_PAGE_LIMIT);
    assign prdata = (paddr[2] == CFG_IDX_PAGE_LIMIT) ? 32'(page_limit) : '0;

    ssca_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    ssca_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .operation     (operation),
        .request_size  (request_size),
        .address       (address),
        .cfg_we        (cfg_we),
        .cfg_wdata     (pwdata[PAGE_CNT_W-1:0]),
        .page_limit    (page_limit),
        .done          (done),
        .status        (status),
        .chunk_address (chunk_address),
        .size_class    (size_class)
    );

endmodule
